// ===== rtl/core/bitsliced_trit_store_top_defines.svh =====
// Assertion macros used by the store's back end (bts_back).
// Each expects clk and rst_n in scope.
`ifndef BITSLICED_TRIT_STORE_TOP_DEFINES_SVH
`define BITSLICED_TRIT_STORE_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bts_pkg.sv =====
`timescale 1ns / 1ps

package bts_pkg;

  localparam int ENTRY_W = 6;
  localparam int LANE_W  = 6;
  localparam int TRIT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int TOUT_W  = 3;
  localparam int ZLANE_W = 7;
  localparam int SUM_W   = 9;

  localparam logic [2:0] CMD_FILL = 3'd0;
  localparam logic [2:0] CMD_SET  = 3'd1;
  localparam logic [2:0] CMD_GET  = 3'd2;
  localparam logic [2:0] CMD_FIND = 3'd3;
  localparam logic [2:0] CMD_SUM  = 3'd4;

  localparam logic [TRIT_W-1:0] TRIT_ZERO = 2'd0;
  localparam logic [TRIT_W-1:0] TRIT_POS  = 2'd1;
  localparam logic [TRIT_W-1:0] TRIT_NAT  = 2'd2;
  localparam logic [TRIT_W-1:0] TRIT_NEG  = 2'd3;

  // Plane bit pairs as {low, high}
  localparam logic [1:0] PLANE_NAT  = 2'b00;
  localparam logic [1:0] PLANE_POS  = 2'b01;
  localparam logic [1:0] PLANE_NEG  = 2'b10;
  localparam logic [1:0] PLANE_ZERO = 2'b11;

  localparam logic signed [TOUT_W-1:0] VAL_NAT  = 3'sd2;
  localparam logic signed [TOUT_W-1:0] VAL_POS  = 3'sd1;
  localparam logic signed [TOUT_W-1:0] VAL_NEG  = -3'sd1;
  localparam logic signed [TOUT_W-1:0] VAL_ZERO = 3'sd0;

  typedef enum logic [2:0] {
    OP_FILL,
    OP_SET,
    OP_GET,
    OP_FIND,
    OP_SUM
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_WR,
    ST_GET_RD,
    ST_SCAN,
    ST_FIN
  } back_state_t;

  typedef struct packed {
    op_t                op;
    logic [ENTRY_W-1:0] entry;
    logic [LANE_W-1:0]  lane;
    logic [TRIT_W-1:0]  trit;
    logic [COUNT_W-1:0] count;
    logic               entry_ok;
    logic               lane_ok;
  } work_item_t;

  function automatic logic enc_low(input logic [TRIT_W-1:0] t);
    return (t == TRIT_ZERO) || (t == TRIT_NEG);
  endfunction

  function automatic logic enc_high(input logic [TRIT_W-1:0] t);
    return (t == TRIT_ZERO) || (t == TRIT_POS);
  endfunction

  function automatic logic signed [TOUT_W-1:0] dec_trit(input logic lo, input logic hi);
    logic signed [TOUT_W-1:0] v;
    unique case ({lo, hi})
      PLANE_POS:  v = VAL_POS;
      PLANE_NEG:  v = VAL_NEG;
      PLANE_ZERO: v = VAL_ZERO;
      default:    v = VAL_NAT;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/bts_front.sv =====
`timescale 1ns / 1ps

module bts_front #(
  parameter int SLICES = 64,
  parameter int DEPTH  = 64
) (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_command,
  input  logic [bts_pkg::ENTRY_W-1:0] in_entry,
  input  logic [bts_pkg::LANE_W-1:0]  in_lane,
  input  logic [bts_pkg::TRIT_W-1:0]  in_trit_in,
  input  logic [bts_pkg::COUNT_W-1:0] in_count,
  output logic                        push_valid,
  input  logic                        push_ready,
  output bts_pkg::work_item_t         push_item
);
  import bts_pkg::*;

  localparam logic [10:0] DEPTH_V  = 11'(DEPTH);
  localparam logic [6:0]  SLICES_V = 7'(SLICES);

  logic cmd_known;
  op_t  op;

  always_comb begin
    cmd_known = 1'b1;
    op        = OP_FILL;
    unique case (in_command)
      CMD_FILL: op = OP_FILL;
      CMD_SET:  op = OP_SET;
      CMD_GET:  op = OP_GET;
      CMD_FIND: op = OP_FIND;
      CMD_SUM:  op = OP_SUM;
      default:  cmd_known = 1'b0;
    endcase
  end

  // Unknown commands are taken and dropped here
  assign in_ready   = push_ready || !cmd_known;
  assign push_valid = in_valid && cmd_known;

  always_comb begin
    push_item.op       = op;
    push_item.entry    = in_entry;
    push_item.lane     = in_lane;
    push_item.trit     = in_trit_in;
    push_item.entry_ok = 11'(in_entry) < DEPTH_V;
    push_item.lane_ok  = 7'(in_lane) < SLICES_V;
    if (11'(in_count) > DEPTH_V) begin
      push_item.count = 7'(DEPTH_V);
    end else begin
      push_item.count = in_count;
    end
  end

endmodule

// ===== rtl/core/bts_queue.sv =====
`timescale 1ns / 1ps

module bts_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  bts_pkg::work_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output bts_pkg::work_item_t pop_item
);
  import bts_pkg::*;

  work_item_t slots_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       push_fire;
  logic       pop_fire;

  assign push_ready = fill_r != 2'd2;
  assign pop_valid  = fill_r != 2'd0;
  assign pop_item   = slots_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_fire) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_r + 2'(push_fire) - 2'(pop_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/bts_back.sv =====
`timescale 1ns / 1ps
`include "bitsliced_trit_store_top_defines.svh"

module bts_back #(
  parameter int SLICES = 64,
  parameter int DEPTH  = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  bts_pkg::work_item_t               pop_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bts_pkg::TOUT_W-1:0] out_trit_out,
  output logic [bts_pkg::ZLANE_W-1:0]       out_zero_lane,
  output logic signed [bts_pkg::SUM_W-1:0]  out_lane_sum
);
  import bts_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Two bit planes, one row per entry
  logic [SLICES-1:0] low_mem  [DEPTH];
  logic [SLICES-1:0] high_mem [DEPTH];

  back_state_t state_r, state_nxt;
  work_item_t  item_r, item_nxt;
  logic [COUNT_W-1:0] idx_r, idx_nxt;
  logic [SLICES-1:0]  acc_r, acc_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SLICES-1:0]  rd_lo_r, rd_hi_r;
  logic               out_valid_r;
  logic signed [TOUT_W-1:0] tout_r, tout_nxt;
  logic [ZLANE_W-1:0] zlane_r, zlane_nxt;
  logic signed [SUM_W-1:0] lsum_r, lsum_nxt;

  logic              out_load;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [SLICES-1:0] wr_lo;
  logic [SLICES-1:0] wr_hi;

  logic [SLICES-1:0] lane_bit;
  logic [63:0]       lo_ext;
  logic [63:0]       hi_ext;
  logic signed [TOUT_W-1:0] cur_trit;
  logic [SLICES-1:0] acc_iso;
  logic [ZLANE_W-1:0] lowest_idx;

  assign lane_bit = SLICES'(64'd1 << item_r.lane);
  assign lo_ext   = 64'(rd_lo_r);
  assign hi_ext   = 64'(rd_hi_r);
  assign cur_trit = dec_trit(lo_ext[item_r.lane], hi_ext[item_r.lane]);

  // Isolate the lowest set bit, then encode its position
  assign acc_iso = acc_r & (~acc_r + SLICES'(1));

  always_comb begin
    lowest_idx = '0;
    for (int i = 0; i < SLICES; i++) begin
      lowest_idx = lowest_idx | (acc_iso[i] ? ZLANE_W'(i) : '0);
    end
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    sum_nxt   = sum_r;
    pop_ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_lo     = '0;
    wr_hi     = '0;
    out_load  = 1'b0;
    tout_nxt  = '0;
    zlane_nxt = '0;
    lsum_nxt  = '0;
    unique case (state_r)
      ST_IDLE: begin
        // Hold off while a result still waits at the output
        pop_ready = !out_valid_r || out_ready;
        if (pop_valid && pop_ready) begin
          item_nxt = pop_item;
          idx_nxt  = '0;
          acc_nxt  = '1;
          sum_nxt  = '0;
          unique case (pop_item.op) inside
            OP_FILL: begin
              wr_en   = pop_item.entry_ok;
              wr_addr = ADDR_W'(pop_item.entry);
              wr_lo   = {SLICES{enc_low(pop_item.trit)}};
              wr_hi   = {SLICES{enc_high(pop_item.trit)}};
            end
            OP_SET: begin
              if (pop_item.entry_ok && pop_item.lane_ok) begin
                rd_en     = 1'b1;
                rd_addr   = ADDR_W'(pop_item.entry);
                state_nxt = ST_SET_WR;
              end
            end
            OP_GET: begin
              rd_en     = pop_item.entry_ok && pop_item.lane_ok;
              rd_addr   = ADDR_W'(pop_item.entry);
              state_nxt = ST_GET_RD;
            end
            OP_FIND, OP_SUM: begin
              if (pop_item.count == '0 || (pop_item.op == OP_SUM && !pop_item.lane_ok)) begin
                state_nxt = ST_FIN;
              end else begin
                rd_en     = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SET_WR: begin
        wr_en     = 1'b1;
        wr_addr   = ADDR_W'(item_r.entry);
        wr_lo     = (rd_lo_r & ~lane_bit) | (enc_low(item_r.trit) ? lane_bit : '0);
        wr_hi     = (rd_hi_r & ~lane_bit) | (enc_high(item_r.trit) ? lane_bit : '0);
        state_nxt = ST_IDLE;
      end
      ST_GET_RD: begin
        out_load  = 1'b1;
        tout_nxt  = (item_r.entry_ok && item_r.lane_ok) ? cur_trit : VAL_NAT;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        // Row idx_r is in the read register; fetch the next one meanwhile
        acc_nxt = acc_r & rd_lo_r & rd_hi_r;
        sum_nxt = sum_r + SUM_W'(cur_trit);
        idx_nxt = idx_r + 7'd1;
        if (idx_nxt < item_r.count) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(idx_nxt);
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        out_load = 1'b1;
        if (item_r.op == OP_FIND) begin
          zlane_nxt = (acc_r == '0) ? ZLANE_W'(SLICES) : lowest_idx;
        end else begin
          lsum_nxt = sum_r;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    idx_r  <= idx_nxt;
    acc_r  <= acc_nxt;
    sum_r  <= sum_nxt;
    if (out_load) begin
      tout_r  <= tout_nxt;
      zlane_r <= zlane_nxt;
      lsum_r  <= lsum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      low_mem[wr_addr]  <= wr_lo;
      high_mem[wr_addr] <= wr_hi;
    end
    if (rd_en) begin
      rd_lo_r <= low_mem[rd_addr];
      rd_hi_r <= high_mem[rd_addr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_trit_out  = tout_r;
  assign out_zero_lane = zlane_r;
  assign out_lane_sum  = lsum_r;

  `BTS_ASSERT_NOW(a_scan_in_range, state_r == ST_SCAN, idx_r < item_r.count, "scan index past count")
  `BTS_ASSERT_NOW(a_result_slot_free, out_load, !out_valid_r || out_ready, "result register overrun")
  `BTS_ASSERT_NOW(a_one_port_op, wr_en, !rd_en, "read and write in the same cycle")
  `BTS_ASSERT_NEXT(a_get_answers, state_r == ST_GET_RD, out_valid_r, "get left no result")

endmodule

// ===== rtl/core/bitsliced_trit_store_top.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Fields
// in       in   in_valid / in_ready    command, entry, lane, trit_in, count
// out      out  out_valid / out_ready  trit_out, zero_lane, lane_sum
//
// Back end steps per item: fill writes when popped; set and get read, then write or decode;
// find_zero and sum_slice pop, read one entry a cycle from the single-port plane
// memory, then finish (a zero count goes straight to finish). Unknown commands are
// dropped at the front in the cycle taken.
// A two-item queue sits between front and back; input is taken while it has room.
// A result holds in the output register until taken; the back stops popping meanwhile.
// Reset clears control only; store contents are undefined until written.

module bitsliced_trit_store_top #(
  parameter int SLICES = 64,
  parameter int DEPTH  = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_command,
  input  logic [bts_pkg::ENTRY_W-1:0]       in_entry,
  input  logic [bts_pkg::LANE_W-1:0]        in_lane,
  input  logic [bts_pkg::TRIT_W-1:0]        in_trit_in,
  input  logic [bts_pkg::COUNT_W-1:0]       in_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bts_pkg::TOUT_W-1:0] out_trit_out,
  output logic [bts_pkg::ZLANE_W-1:0]       out_zero_lane,
  output logic signed [bts_pkg::SUM_W-1:0]  out_lane_sum
);
  import bts_pkg::*;

  logic       push_valid;
  logic       push_ready;
  work_item_t push_item;
  logic       pop_valid;
  logic       pop_ready;
  work_item_t pop_item;

  bts_front #(
    .SLICES(SLICES),
    .DEPTH (DEPTH)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_command(in_command),
    .in_entry  (in_entry),
    .in_lane   (in_lane),
    .in_trit_in(in_trit_in),
    .in_count  (in_count),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item)
  );

  bts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  bts_back #(
    .SLICES(SLICES),
    .DEPTH (DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_trit_out (out_trit_out),
    .out_zero_lane(out_zero_lane),
    .out_lane_sum (out_lane_sum)
  );

endmodule
